// File: src/pgnt_pkg.sv
// ----------------------------------------------------------------------------
// pgnt_pkg: shared types and constants
// formats, command codes and controller states of the noise/turbulence unit
// ----------------------------------------------------------------------------
package pgnt_pkg;

  localparam int FRAC_BITS  = 16;              // query fraction bits
  localparam int GRAD_FRAC  = 14;              // gradient fraction bits
  localparam int IDX_W      = 8;               // table index width
  localparam int TABLE_SIZE = 1 << IDX_W;
  localparam int POS_W      = IDX_W + FRAC_BITS;
  localparam int GRAD_W     = 16;
  localparam int PERM_W     = 8;
  localparam int OUT_W      = FRAC_BITS + 3;
  localparam int D_W        = FRAC_BITS + 2;   // signed corner offset
  localparam int W_W        = FRAC_BITS + 1;   // blend weight, up to one
  localparam int DOT_W      = 24;
  localparam int ACC_W      = 32;
  localparam int OCT_W      = 4;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'b1;
  localparam logic [OCT_W-1:0]     OCT_RESET   = 4'd7;

  typedef enum logic [2:0] {
    KIND_QUERY  = 3'd0,
    KIND_PERM_X = 3'd1,
    KIND_PERM_Y = 3'd2,
    KIND_PERM_Z = 3'd3,
    KIND_GRAD   = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMOOTH_A,
    ST_SMOOTH_B,
    ST_ADDR,
    ST_PERM,
    ST_GRAD,
    ST_DOT,
    ST_TERM,
    ST_ACCUM,
    ST_OCT_END,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_SMOOTH_A,
    OP_SMOOTH_B,
    OP_ADDR,
    OP_PERM,
    OP_GRAD,
    OP_DOT,
    OP_TERM,
    OP_ACCUM,
    OP_OCT_END,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [2:0]       corner;   // {di, dj, dk}
    logic [OCT_W-1:0] octave;
    logic             noise_mode;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

// File: src/pgnt_if.sv
// ----------------------------------------------------------------------------
// pgnt_in_if / pgnt_out_if: valid/ready channels
// query/load items in, noise results out
// ----------------------------------------------------------------------------
interface pgnt_in_if import pgnt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [IDX_W-1:0]  table_index;
  logic [PERM_W-1:0] perm_entry;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic signed [GRAD_W-1:0] grad_z;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [POS_W-1:0]  pos_z;

  modport source (output valid, kind, table_index, perm_entry, grad_x, grad_y, grad_z,
                  pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, kind, table_index, perm_entry, grad_x, grad_y, grad_z,
                  pos_x, pos_y, pos_z, output ready);
endinterface

interface pgnt_out_if import pgnt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// File: src/pgnt_ram.sv
// ----------------------------------------------------------------------------
// pgnt_ram: generic simple dual-port ram
// one write port, one read port with registered data
// ----------------------------------------------------------------------------
module pgnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: src/pgnt_ctrl.sv
// ----------------------------------------------------------------------------
// pgnt_ctrl: sequencer
// config registers, octave/corner counters and the step state machine
// ----------------------------------------------------------------------------
module pgnt_ctrl import pgnt_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [2:0]            in_kind,
  output logic                  in_ready,
  input  logic                  out_ready,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_status_t            status,
  output dp_cmd_t               cmd
);

  localparam int CW = $clog2(MAX_OCTAVES + 1);

  state_t           state_r, state_nxt;
  logic [OCT_W-1:0] octaves_cfg_r;
  logic             mode_cfg_r;
  logic             mode_r;
  logic [2:0]       corner_r;
  logic [CW-1:0]    oct_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             accept;
  logic             is_query;
  logic             is_load;
  logic             can_finish;

  assign accept     = in_valid && in_ready;
  assign is_query   = in_kind == KIND_QUERY;
  assign is_load    = in_kind == KIND_PERM_X || in_kind == KIND_PERM_Y ||
                      in_kind == KIND_PERM_Z || in_kind == KIND_GRAD;
  assign can_finish = !status.out_full || out_ready;

  always_comb begin
    if (mode_cfg_r) begin
      count_nxt = CW'(1);
    end else if (int'(octaves_cfg_r) > MAX_OCTAVES) begin
      count_nxt = CW'(MAX_OCTAVES);
    end else begin
      count_nxt = CW'(octaves_cfg_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_nxt = (count_nxt == '0) ? ST_FINISH : ST_SMOOTH_A;
        end
      end
      ST_SMOOTH_A: state_nxt = ST_SMOOTH_B;
      ST_SMOOTH_B: state_nxt = ST_ADDR;
      ST_ADDR:     state_nxt = ST_PERM;
      ST_PERM:     state_nxt = ST_GRAD;
      ST_GRAD:     state_nxt = ST_DOT;
      ST_DOT:      state_nxt = ST_TERM;
      ST_TERM:     state_nxt = ST_ACCUM;
      ST_ACCUM:    state_nxt = (corner_r == 3'd7) ? ST_OCT_END : ST_ADDR;
      ST_OCT_END:  state_nxt = (oct_r + CW'(1) == count_r) ? ST_FINISH : ST_SMOOTH_A;
      ST_FINISH: begin
        if (can_finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.op         = OP_NONE;
    cmd.corner     = corner_r;
    cmd.octave     = OCT_W'(oct_r);
    cmd.noise_mode = mode_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && is_query) begin
          cmd.op = OP_START;
        end else if (accept && is_load) begin
          cmd.op = OP_LOAD;
        end
      end
      ST_SMOOTH_A: cmd.op = OP_SMOOTH_A;
      ST_SMOOTH_B: cmd.op = OP_SMOOTH_B;
      ST_ADDR:     cmd.op = OP_ADDR;
      ST_PERM:     cmd.op = OP_PERM;
      ST_GRAD:     cmd.op = OP_GRAD;
      ST_DOT:      cmd.op = OP_DOT;
      ST_TERM:     cmd.op = OP_TERM;
      ST_ACCUM:    cmd.op = OP_ACCUM;
      ST_OCT_END:  cmd.op = OP_OCT_END;
      ST_FINISH:   cmd.op = can_finish ? OP_FINISH : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      octaves_cfg_r <= OCT_RESET;
      mode_cfg_r    <= 1'b0;
      mode_r        <= 1'b0;
      corner_r      <= '0;
      oct_r         <= '0;
      count_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_OCTAVES: octaves_cfg_r <= cfg_data;
          CFG_MODE:    mode_cfg_r    <= cfg_data[0];
          default:     ;
        endcase
      end
      if (state_r == ST_IDLE && accept && is_query) begin
        mode_r   <= mode_cfg_r;
        count_r  <= count_nxt;
        oct_r    <= '0;
        corner_r <= '0;
      end
      if (state_r == ST_ACCUM) begin
        corner_r <= corner_r + 3'd1;
      end
      if (state_r == ST_OCT_END) begin
        oct_r <= oct_r + CW'(1);
      end
    end
  end

endmodule

// File: src/pgnt_dp.sv
// ----------------------------------------------------------------------------
// pgnt_dp: datapath
// tables, smoothing, gradient dot products, blend and octave accumulation
// ----------------------------------------------------------------------------
module pgnt_dp import pgnt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  input  logic [2:0]               in_kind,
  input  logic [IDX_W-1:0]         in_table_index,
  input  logic [PERM_W-1:0]        in_perm_entry,
  input  logic signed [GRAD_W-1:0] in_grad_x,
  input  logic signed [GRAD_W-1:0] in_grad_y,
  input  logic signed [GRAD_W-1:0] in_grad_z,
  input  logic [POS_W-1:0]         in_pos_x,
  input  logic [POS_W-1:0]         in_pos_y,
  input  logic [POS_W-1:0]         in_pos_z,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [OUT_W-1:0]  out_noise_value,
  output dp_status_t               status
);

  localparam logic signed [D_W-1:0] ONE_D = D_W'(1 << FRAC_BITS);
  localparam logic [W_W-1:0]         ONE_W = W_W'(1 << FRAC_BITS);
  localparam logic [D_W-1:0]         THREE = D_W'(3 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(1 << (OUT_W - 1));
  localparam int PR_W = GRAD_W + D_W;

  logic [POS_W-1:0]     px_r, py_r, pz_r;
  logic [FRAC_BITS-1:0] t2x_r, t2y_r, t2z_r;
  logic [FRAC_BITS-1:0] sx_r, sy_r, sz_r;
  logic signed [PR_W-1:0]  prx_r, pry_r, prz_r;
  logic [W_W-1:0]       wxy_r, w_r;
  logic signed [DOT_W-1:0] dot_r;
  logic signed [DOT_W+W_W:0] term_r;
  logic signed [ACC_W-1:0] oct_acc_r, total_r;
  logic                 out_valid_r;
  logic signed [OUT_W-1:0] out_r;

  logic [FRAC_BITS-1:0] fx, fy, fz;
  logic [PERM_W-1:0]    permx, permy, permz;
  logic [3*GRAD_W-1:0]  grad_rd;
  logic [IDX_W-1:0]     gaddr;
  logic                 we_x, we_y, we_z, we_g;
  logic signed [D_W-1:0] du, dv, dw;
  logic [W_W-1:0]       wx, wy, wz;
  logic [2*W_W-1:0]     pwxy, pw;
  logic signed [PR_W+1:0] dsum;
  logic [2*FRAC_BITS-1:0] sqx, sqy, sqz;
  logic [FRAC_BITS+D_W-1:0] smx, smy, smz;
  logic signed [ACC_W-1:0] mag, sat;

  assign fx = px_r[FRAC_BITS-1:0];
  assign fy = py_r[FRAC_BITS-1:0];
  assign fz = pz_r[FRAC_BITS-1:0];

  assign we_x = cmd.op == OP_LOAD && in_kind == KIND_PERM_X;
  assign we_y = cmd.op == OP_LOAD && in_kind == KIND_PERM_Y;
  assign we_z = cmd.op == OP_LOAD && in_kind == KIND_PERM_Z;
  assign we_g = cmd.op == OP_LOAD && in_kind == KIND_GRAD;

  pgnt_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_x (
    .clk, .we(we_x), .waddr(in_table_index), .wdata(in_perm_entry),
    .raddr(px_r[POS_W-1:FRAC_BITS] + IDX_W'(cmd.corner[2])), .rdata_r(permx));
  pgnt_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_y (
    .clk, .we(we_y), .waddr(in_table_index), .wdata(in_perm_entry),
    .raddr(py_r[POS_W-1:FRAC_BITS] + IDX_W'(cmd.corner[1])), .rdata_r(permy));
  pgnt_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_z (
    .clk, .we(we_z), .waddr(in_table_index), .wdata(in_perm_entry),
    .raddr(pz_r[POS_W-1:FRAC_BITS] + IDX_W'(cmd.corner[0])), .rdata_r(permz));

  assign gaddr = IDX_W'(permx ^ permy ^ permz);

  pgnt_ram #(.WIDTH(3*GRAD_W), .DEPTH(TABLE_SIZE)) u_grad (
    .clk, .we(we_g), .waddr(in_table_index), .wdata({in_grad_x, in_grad_y, in_grad_z}),
    .raddr(gaddr), .rdata_r(grad_rd));

  // smoothing: t^2, then t^2 * (3 - 2t)
  assign sqx = fx * fx;
  assign sqy = fy * fy;
  assign sqz = fz * fz;
  assign smx = t2x_r * (THREE - D_W'({fx, 1'b0}));
  assign smy = t2y_r * (THREE - D_W'({fy, 1'b0}));
  assign smz = t2z_r * (THREE - D_W'({fz, 1'b0}));

  // corner offsets and blend weights
  assign du = $signed({2'b00, fx}) - (cmd.corner[2] ? ONE_D : '0);
  assign dv = $signed({2'b00, fy}) - (cmd.corner[1] ? ONE_D : '0);
  assign dw = $signed({2'b00, fz}) - (cmd.corner[0] ? ONE_D : '0);
  assign wx = cmd.corner[2] ? {1'b0, sx_r} : ONE_W - {1'b0, sx_r};
  assign wy = cmd.corner[1] ? {1'b0, sy_r} : ONE_W - {1'b0, sy_r};
  assign wz = cmd.corner[0] ? {1'b0, sz_r} : ONE_W - {1'b0, sz_r};
  assign pwxy = wx * wy;
  assign pw   = wxy_r * wz;

  assign dsum = (PR_W+2)'(prx_r) + (PR_W+2)'(pry_r) + (PR_W+2)'(prz_r);

  assign mag = (!cmd.noise_mode && total_r < 0) ? -total_r : total_r;
  always_comb begin
    if (mag > SAT_HI) begin
      sat = SAT_HI;
    end else if (mag < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = mag;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        px_r    <= in_pos_x;
        py_r    <= in_pos_y;
        pz_r    <= in_pos_z;
        total_r <= '0;
      end
      OP_SMOOTH_A: begin
        t2x_r <= sqx[2*FRAC_BITS-1:FRAC_BITS];
        t2y_r <= sqy[2*FRAC_BITS-1:FRAC_BITS];
        t2z_r <= sqz[2*FRAC_BITS-1:FRAC_BITS];
      end
      OP_SMOOTH_B: begin
        sx_r      <= smx[2*FRAC_BITS-1:FRAC_BITS];
        sy_r      <= smy[2*FRAC_BITS-1:FRAC_BITS];
        sz_r      <= smz[2*FRAC_BITS-1:FRAC_BITS];
        oct_acc_r <= '0;
      end
      OP_GRAD: begin
        prx_r <= $signed(grad_rd[3*GRAD_W-1:2*GRAD_W]) * du;
        pry_r <= $signed(grad_rd[2*GRAD_W-1:GRAD_W]) * dv;
        prz_r <= $signed(grad_rd[GRAD_W-1:0]) * dw;
        wxy_r <= pwxy[FRAC_BITS+W_W-1:FRAC_BITS];
      end
      OP_DOT: begin
        dot_r <= DOT_W'(dsum >>> GRAD_FRAC);
        w_r   <= pw[FRAC_BITS+W_W-1:FRAC_BITS];
      end
      OP_TERM: begin
        term_r <= $signed({1'b0, w_r}) * dot_r;
      end
      OP_ACCUM: begin
        oct_acc_r <= oct_acc_r + ACC_W'(term_r >>> FRAC_BITS);
      end
      OP_OCT_END: begin
        total_r <= total_r + (oct_acc_r >>> cmd.octave);
        px_r    <= {px_r[POS_W-2:0], 1'b0};
        py_r    <= {py_r[POS_W-2:0], 1'b0};
        pz_r    <= {pz_r[POS_W-2:0], 1'b0};
      end
      OP_FINISH: begin
        out_r <= OUT_W'(sat);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_r;
  assign status.out_full = out_valid_r;

endmodule

// File: src/perlin_gradient_noise_turbulence_unit.sv
// ----------------------------------------------------------------------------
// perlin_gradient_noise_turbulence_unit: 3-d gradient noise and turbulence
// sequenced fixed-point noise engine with loadable permutation/gradient tables
// ----------------------------------------------------------------------------
// usage
//   in_ch carries load items (kinds 1..4) and query items (kind 0); a transfer
//   happens when valid and ready are both high. loads write one table entry in
//   the transfer cycle and produce no result; kinds 5..7 are dropped.
//   out_ch carries one noise_value per query, held in an output register.
//   cfg_wr_en/cfg_index/cfg_data write octave_count (0) or signed_noise_mode
//   (1); write only while the unit is idle.
// sequence
//   each octave runs 2 smoothing steps, then 6 steps per lattice
//   corner (address, perm read, gradient read, dot product, term, accumulate)
//   through a chain of registered multiply steps, then 1 octave fold.
//   a query runs N octaves (N is octave_count capped at MAX_OCTAVES, 1 in
//   noise mode; zero octaves go straight to the result); the unit is idle again
//   and takes the next item when the result becomes valid; after a load it stays idle.
// reset and stall
//   reset clears control and config (octave_count 7, turbulence mode); tables
//   are not cleared and must be loaded before querying. if out_ch stalls, the
//   finished result waits in the output register and the unit takes further
//   load and query items; a second result waits until the first is taken.
module perlin_gradient_noise_turbulence_unit import pgnt_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pgnt_in_if.sink               in_ch,
  pgnt_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;     // step command from sequencer
  dp_status_t status;  // output register occupancy

  pgnt_ctrl #(.MAX_OCTAVES(MAX_OCTAVES)) u_ctrl (
    .clk,
    .rst_n,
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .cfg_wr_en,
    .cfg_index,
    .cfg_data,
    .status,
    .cmd
  );

  pgnt_dp u_dp (
    .clk,
    .rst_n,
    .cmd,
    .in_kind         (in_ch.kind),
    .in_table_index  (in_ch.table_index),
    .in_perm_entry   (in_ch.perm_entry),
    .in_grad_x       (in_ch.grad_x),
    .in_grad_y       (in_ch.grad_y),
    .in_grad_z       (in_ch.grad_z),
    .in_pos_x        (in_ch.pos_x),
    .in_pos_y        (in_ch.pos_y),
    .in_pos_z        (in_ch.pos_z),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_noise_value (out_ch.noise_value),
    .status
  );

endmodule

// File: src/pgnt_checker.sv
// ----------------------------------------------------------------------------
// pgnt_checker: port-level checks
// result channel behavior and query/load sequencing seen at the ports
// ----------------------------------------------------------------------------
module pgnt_checker import pgnt_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [2:0]              in_kind,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_noise
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a query occupies the engine
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_QUERY |=> !in_ready)
    else $error("input taken right after query");

  // loads never make a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind != KIND_QUERY && !out_valid |=> !out_valid)
    else $error("result after load transfer");

endmodule

bind perlin_gradient_noise_turbulence_unit pgnt_checker u_pgnt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_kind   (in_ch.kind),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_noise (out_ch.noise_value)
);
